FILE: rtl/ppeu_pkg.sv
package ppeu_pkg;

  localparam int SLOT_BITS = 6;

  localparam logic [1:0] CMD_SPAWN = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic        [1:0]  cmd;
    logic signed [15:0] spawn_x;
    logic signed [15:0] spawn_y;
    logic signed [15:0] spawn_z;
    logic signed [15:0] speed_x;
    logic signed [15:0] speed_y;
    logic signed [15:0] speed_z;
    logic signed [15:0] fall_rate;
    logic        [15:0] lifetime;
    logic        [15:0] tint;
    logic        [15:0] extent;
    logic        [15:0] time_step;
  } req_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0] slot;
    logic signed [15:0]   out_x;
    logic signed [15:0]   out_y;
    logic signed [15:0]   out_z;
    logic [15:0]          life_left;
    logic [15:0]          life_full;
    logic [15:0]          out_tint;
    logic [15:0]          out_extent;
    logic                 last;
  } rsp_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic signed [15:0] grav;
    logic [15:0]        life_left;
    logic [15:0]        life_full;
    logic [15:0]        tint;
    logic [15:0]        extent;
  } entry_t;

  typedef struct packed {
    logic                 spawn;
    logic                 clear;
    logic                 tick_start;
    logic                 cap;
    logic                 commit;
    logic                 flush;
    logic [SLOT_BITS-1:0] slot;
  } ctl_t;

  typedef struct packed {
    logic live_cur;
    logic survive;
    logic hold_valid;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/ppeu_ram.sv
module ppeu_ram #(
  parameter int WIDTH = 176,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/ppeu_ctrl.sv
module ppeu_ctrl #(
  parameter int POOL_SIZE = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic [1:0]          req_cmd,
  output logic                req_ready,
  input  ppeu_pkg::sts_t      sts,
  output ppeu_pkg::ctl_t      ctl
);

  localparam int SLOT_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_MUL,
    S_UPD,
    S_FLUSH
  } state_t;

  state_t            state;
  logic [SLOT_W-1:0] slot;
  logic              last_slot;

  assign last_slot = (slot == SLOT_W'(POOL_SIZE - 1));
  assign req_ready = (state == S_IDLE);

  always_comb begin
    ctl = '0;
    ctl.slot = ppeu_pkg::SLOT_BITS'(slot);
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (req_cmd)
            ppeu_pkg::CMD_SPAWN: ctl.spawn = 1'b1;
            ppeu_pkg::CMD_TICK:  ctl.tick_start = 1'b1;
            ppeu_pkg::CMD_CLEAR: ctl.clear = 1'b1;
            default: ;
          endcase
        end
      end
      S_RD: ;
      S_MUL: ctl.cap = 1'b1;
      S_UPD: ctl.commit = !(sts.survive && sts.hold_valid && !sts.out_free);
      S_FLUSH: ctl.flush = sts.hold_valid && sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ctl.tick_start) begin
            slot  <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          if (sts.live_cur) begin
            state <= S_MUL;
          end else if (last_slot) begin
            state <= S_FLUSH;
          end else begin
            slot <= slot + 1'b1;
          end
        end
        S_MUL: state <= S_UPD;
        S_UPD: begin
          if (ctl.commit) begin
            if (last_slot) begin
              state <= S_FLUSH;
            end else begin
              slot  <= slot + 1'b1;
              state <= S_RD;
            end
          end
        end
        S_FLUSH: begin
          if (!sts.hold_valid || sts.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_upd_entry: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD |-> $past(state) == S_MUL || $past(state) == S_UPD)
    else $error("update stage entered without product stage");

  a_tick_start: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_cmd == ppeu_pkg::CMD_TICK |=> state == S_RD && slot == '0)
    else $error("tick did not start sweep at slot zero");

endmodule

FILE: rtl/ppeu_dpath.sv
module ppeu_dpath #(
  parameter int POOL_SIZE = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  ppeu_pkg::req_t req,
  input  ppeu_pkg::ctl_t ctl,
  output ppeu_pkg::sts_t sts,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output ppeu_pkg::rsp_t rsp
);

  localparam int SLOT_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int ENT_W  = $bits(ppeu_pkg::entry_t);

  function automatic logic signed [15:0] sat16(input logic signed [25:0] v);
    logic signed [15:0] r;
    if (v > 26'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -26'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic [POOL_SIZE-1:0] live;
  logic [SLOT_W-1:0]    next_slot;
  logic [SLOT_W-1:0]    cur;
  logic [15:0]          dt;

  ppeu_pkg::entry_t rd_ent;
  ppeu_pkg::entry_t ent;
  ppeu_pkg::entry_t upd_ent;
  ppeu_pkg::entry_t spawn_ent;
  ppeu_pkg::entry_t wr_ent;
  logic [ENT_W-1:0] rd_raw;
  logic             we;
  logic [SLOT_W-1:0] waddr;

  logic signed [32:0] prod_x, prod_y, prod_z, prod_g;
  logic signed [24:0] pq_x, pq_y, pq_z, pq_g;
  logic signed [25:0] sum_x, sum_y, sum_z, sum_vy;

  ppeu_pkg::rsp_t hold;
  ppeu_pkg::rsp_t fin_rsp;
  ppeu_pkg::rsp_t new_rsp;
  logic           hold_valid;
  logic           survive;
  logic           push_mid;
  logic           push_fin;

  assign cur = ctl.slot[SLOT_W-1:0];

  assign spawn_ent.pos_x     = req.spawn_x;
  assign spawn_ent.pos_y     = req.spawn_y;
  assign spawn_ent.pos_z     = req.spawn_z;
  assign spawn_ent.vel_x     = req.speed_x;
  assign spawn_ent.vel_y     = req.speed_y;
  assign spawn_ent.vel_z     = req.speed_z;
  assign spawn_ent.grav      = req.fall_rate;
  assign spawn_ent.life_left = req.lifetime;
  assign spawn_ent.life_full = req.lifetime;
  assign spawn_ent.tint      = req.tint;
  assign spawn_ent.extent    = req.extent;

  assign rd_ent = ppeu_pkg::entry_t'(rd_raw);

  assign prod_x = $signed(rd_ent.vel_x) * $signed({1'b0, dt});
  assign prod_y = $signed(rd_ent.vel_y) * $signed({1'b0, dt});
  assign prod_z = $signed(rd_ent.vel_z) * $signed({1'b0, dt});
  assign prod_g = $signed(rd_ent.grav) * $signed({1'b0, dt});

  assign sum_x  = 26'($signed(ent.pos_x)) + 26'(pq_x);
  assign sum_y  = 26'($signed(ent.pos_y)) + 26'(pq_y);
  assign sum_z  = 26'($signed(ent.pos_z)) + 26'(pq_z);
  assign sum_vy = 26'($signed(ent.vel_y)) - 26'(pq_g);

  assign survive = (ent.life_left > dt);

  always_comb begin
    upd_ent           = ent;
    upd_ent.pos_x     = sat16(sum_x);
    upd_ent.pos_y     = sat16(sum_y);
    upd_ent.pos_z     = sat16(sum_z);
    upd_ent.vel_y     = sat16(sum_vy);
    upd_ent.life_left = ent.life_left - dt;
  end

  always_comb begin
    new_rsp.slot       = ctl.slot;
    new_rsp.out_x      = upd_ent.pos_x;
    new_rsp.out_y      = upd_ent.pos_y;
    new_rsp.out_z      = upd_ent.pos_z;
    new_rsp.life_left  = upd_ent.life_left;
    new_rsp.life_full  = ent.life_full;
    new_rsp.out_tint   = ent.tint;
    new_rsp.out_extent = ent.extent;
    new_rsp.last       = 1'b0;
  end

  always_comb begin
    fin_rsp      = hold;
    fin_rsp.last = 1'b1;
  end

  assign we     = ctl.spawn || (ctl.commit && survive);
  assign waddr  = ctl.spawn ? next_slot : cur;
  assign wr_ent = ctl.spawn ? spawn_ent : upd_ent;

  ppeu_ram #(
    .WIDTH (ENT_W),
    .DEPTH (POOL_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_ent),
    .raddr (cur),
    .rdata (rd_raw)
  );

  assign push_mid = ctl.commit && survive && hold_valid;
  assign push_fin = ctl.flush;

  assign sts.live_cur   = live[cur];
  assign sts.survive    = survive;
  assign sts.hold_valid = hold_valid;
  assign sts.out_free   = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (ctl.tick_start) begin
      dt <= req.time_step;
    end
    if (ctl.cap) begin
      ent  <= rd_ent;
      pq_x <= prod_x[32:8];
      pq_y <= prod_y[32:8];
      pq_z <= prod_z[32:8];
      pq_g <= prod_g[32:8];
    end
    if (ctl.commit && survive) begin
      hold <= new_rsp;
    end
    if (push_mid) begin
      rsp <= hold;
    end else if (push_fin) begin
      rsp <= fin_rsp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live       <= '0;
      next_slot  <= '0;
      hold_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (ctl.clear) begin
        live      <= '0;
        next_slot <= '0;
      end else if (ctl.spawn) begin
        live[next_slot] <= 1'b1;
        next_slot <= (next_slot == SLOT_W'(POOL_SIZE - 1)) ? '0 : next_slot + 1'b1;
      end else if (ctl.commit && !survive) begin
        live[cur] <= 1'b0;
      end
      if (ctl.commit && survive) begin
        hold_valid <= 1'b1;
      end else if (push_fin) begin
        hold_valid <= 1'b0;
      end
      if (push_mid || push_fin) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    push_mid || push_fin |-> !rsp_valid || rsp_ready)
    else $error("pending response overwritten");

  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    ctl.flush |=> !hold_valid)
    else $error("hold register still full after flush");

  a_hold_load: assert property (@(posedge clk) disable iff (rst)
    ctl.commit && survive |=> hold_valid && hold.slot == $past(ctl.slot))
    else $error("survivor not captured in hold register");

endmodule

FILE: rtl/particle_pool_euler_update.sv
// Particle pool with explicit Euler integration, signed Q8.8 arithmetic.
// Request channel (req_valid/req_ready/req): cmd 0 spawns into the next ring
// slot, cmd 1 is a time tick of req.time_step, cmd 2 clears the pool,
// cmd 3 is ignored. A request is taken only while the block is idle.
// Spawn, clear and ignored commands give no response.
// A tick sweeps every slot in ascending order: a dead slot is skipped,
// a live slot goes through RAM read, multiply and update/write-back, and
// a final drain step sends the last held response, if there is one.
// Response channel (rsp_valid/rsp_ready/rsp): one response per surviving
// particle, rsp.last set on the final one; an empty tick gives none.
// Survivors pass through a hold register and an output register, so the
// sweep stalls only when both are full and the receiver holds rsp_ready low.
// Reset empties the pool (all slots dead) and returns the spawn slot to 0;
// the pool RAM itself is not cleared and needs no clearing pass.
module particle_pool_euler_update #(
  parameter int POOL_SIZE = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  ppeu_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output ppeu_pkg::rsp_t rsp
);

  ppeu_pkg::ctl_t ctl;
  ppeu_pkg::sts_t sts;

  ppeu_ctrl #(
    .POOL_SIZE (POOL_SIZE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_cmd   (req.cmd),
    .req_ready (req_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  ppeu_dpath #(
    .POOL_SIZE (POOL_SIZE)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ctl       (ctl),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

FILE: verif/tb_particle_pool_euler_update.sv
`timescale 1ns / 1ps

module tb_particle_pool_euler_update;

  localparam int POOL = 64;
  localparam int ITEMS = 470;
  localparam int HOLD_OFF = 400;
  localparam int DRAIN_CYCLES = 3 * POOL + 10;
  localparam int unsigned LIMIT = 4_000_000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Euler-step predictor of the pool plus the queue of particle updates it expects.
  class particle_tracker;
    bit                 alive [POOL];
    logic signed [15:0] pos [POOL][3];
    logic signed [15:0] vel [POOL][3];
    logic signed [15:0] grav [POOL];
    logic [15:0]        life_left [POOL];
    logic [15:0]        life_full [POOL];
    logic [15:0]        tint [POOL];
    logic [15:0]        extent [POOL];
    int                 next_slot;
    ppeu_pkg::rsp_t     pending [$];
    int                 errors;
    int                 checked;
    int                 spawns;
    int                 ticks;
    int                 clears;
    int                 peak;

    function new();
      foreach (alive[i]) alive[i] = 1'b0;
      next_slot = 0;
    endfunction

    function logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
    endfunction

    // v * dt is Q16.16; dropping 8 bits floors toward minus infinity
    function longint scaled(logic signed [15:0] v, logic [15:0] dt);
      longint p;
      p = longint'(v) * longint'(dt);
      return p >>> 8;
    endfunction

    function void apply_request(ppeu_pkg::req_t r);
      ppeu_pkg::rsp_t e;
      ppeu_pkg::rsp_t held;
      bit   have;
      int   s;
      int   n_out;
      logic [15:0] dt;
      have = 1'b0;
      n_out = 0;
      case (r.cmd)
        ppeu_pkg::CMD_SPAWN: begin
          s = next_slot;
          pos[s][0] = r.spawn_x;
          pos[s][1] = r.spawn_y;
          pos[s][2] = r.spawn_z;
          vel[s][0] = r.speed_x;
          vel[s][1] = r.speed_y;
          vel[s][2] = r.speed_z;
          grav[s] = r.fall_rate;
          life_left[s] = r.lifetime;
          life_full[s] = r.lifetime;
          tint[s] = r.tint;
          extent[s] = r.extent;
          alive[s] = 1'b1;
          next_slot = (s + 1) % POOL;
          spawns++;
        end
        ppeu_pkg::CMD_CLEAR: begin
          foreach (alive[i]) alive[i] = 1'b0;
          next_slot = 0;
          clears++;
        end
        ppeu_pkg::CMD_TICK: begin
          dt = r.time_step;
          ticks++;
          for (int i = 0; i < POOL; i++) begin
            if (!alive[i]) continue;
            if (life_left[i] <= dt) begin
              alive[i] = 1'b0;
              continue;
            end
            life_left[i] = life_left[i] - dt;
            for (int k = 0; k < 3; k++)
              pos[i][k] = clamp16(longint'(pos[i][k]) + scaled(vel[i][k], dt));
            vel[i][1] = clamp16(longint'(vel[i][1]) - scaled(grav[i], dt));
            e.slot = 6'(i);
            e.out_x = pos[i][0];
            e.out_y = pos[i][1];
            e.out_z = pos[i][2];
            e.life_left = life_left[i];
            e.life_full = life_full[i];
            e.out_tint = tint[i];
            e.out_extent = extent[i];
            e.last = 1'b0;
            if (have) pending.push_back(held);
            held = e;
            have = 1'b1;
            n_out++;
          end
          if (have) begin
            held.last = 1'b1;
            pending.push_back(held);
          end
          if (n_out > peak) peak = n_out;
        end
        default: ;
      endcase
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s expected %h got %h", $time, name, want, got);
      end
    endfunction

    function void check_update(ppeu_pkg::rsp_t got);
      ppeu_pkg::rsp_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: update for slot %0d with none expected", $time, got.slot);
        return;
      end
      want = pending.pop_front();
      checked++;
      compare("slot", want.slot, got.slot);
      compare("out_x", want.out_x, got.out_x);
      compare("out_y", want.out_y, got.out_y);
      compare("out_z", want.out_z, got.out_z);
      compare("life_left", want.life_left, got.life_left);
      compare("life_full", want.life_full, got.life_full);
      compare("out_tint", want.out_tint, got.out_tint);
      compare("out_extent", want.out_extent, got.out_extent);
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  ppeu_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  ppeu_pkg::rsp_t rsp;

  particle_tracker tracker = new();
  int unsigned cycles = 0;
  int sent = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit hold_off_pending = 1'b0;
  int long_holds = 0;

  particle_pool_euler_update #(.POOL_SIZE(POOL)) DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= LIMIT);
    $display("tb_particle_pool_euler_update: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) tracker.check_update(rsp);
  end

  function automatic ppeu_pkg::req_t rand_req();
    logic [191:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return bits[$bits(ppeu_pkg::req_t)-1:0];
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return 16'($urandom_range(0, 1024) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_life();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'($urandom_range(1, 255));
      2: return 16'($urandom);
      default: return 16'($urandom_range(16'h0400, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(0, 11))
      0: return 16'h0000;
      1: return 16'($urandom);
      default: return 16'($urandom_range(1, 16'h0180));
    endcase
  endfunction

  function automatic ppeu_pkg::req_t make_spawn();
    ppeu_pkg::req_t r;
    r = rand_req();
    r.cmd = ppeu_pkg::CMD_SPAWN;
    r.spawn_x = pick_value();
    r.spawn_y = pick_value();
    r.spawn_z = pick_value();
    r.speed_x = pick_value();
    r.speed_y = pick_value();
    r.speed_z = pick_value();
    r.fall_rate = pick_value();
    r.lifetime = pick_life();
    return r;
  endfunction

  function automatic ppeu_pkg::req_t spawn_of(logic [15:0] px, logic [15:0] py,
                                              logic [15:0] pz, logic [15:0] vx,
                                              logic [15:0] vy, logic [15:0] vz,
                                              logic [15:0] g, logic [15:0] life,
                                              logic [15:0] t, logic [15:0] ext);
    ppeu_pkg::req_t r;
    r = rand_req();
    r.cmd = ppeu_pkg::CMD_SPAWN;
    r.spawn_x = px;
    r.spawn_y = py;
    r.spawn_z = pz;
    r.speed_x = vx;
    r.speed_y = vy;
    r.speed_z = vz;
    r.fall_rate = g;
    r.lifetime = life;
    r.tint = t;
    r.extent = ext;
    return r;
  endfunction

  function automatic ppeu_pkg::req_t make_cmd(logic [1:0] c, logic [15:0] dt);
    ppeu_pkg::req_t r;
    r = rand_req();
    r.cmd = c;
    r.time_step = dt;
    return r;
  endfunction

  task automatic send_req(input ppeu_pkg::req_t r);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    tracker.apply_request(r);
    if (r.cmd != CMD_UNUSED) sent++;
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : rsp_side
    int gap;
    wait (!rst);
    forever begin
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        rsp_ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        long_holds++;
      end else begin
        gap = rx_steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
          rsp_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!(rsp_valid && rsp_ready));
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
    end
  end

  initial begin : req_side
    ppeu_pkg::req_t all_ones;
    int n;
    all_ones = '1;
    all_ones.cmd = CMD_UNUSED;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty pool, unused command, field extremes, rounding and saturation
    send_req(make_cmd(ppeu_pkg::CMD_TICK, 16'd100));
    send_req(all_ones);
    send_req(spawn_of(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                      16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_req(spawn_of(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                      16'h7FFF, 16'h0200, 16'h0000, 16'h0000));
    send_req(spawn_of(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                      16'h0000, 16'h0000, 16'h1234, 16'h5678));
    send_req(spawn_of(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 16'hFFFF,
                      16'h0001, 16'h0001, 16'hA5A5, 16'h0100));
    send_req(make_cmd(ppeu_pkg::CMD_TICK, 16'h0000));
    send_req(make_cmd(ppeu_pkg::CMD_TICK, 16'h0001));
    send_req(make_cmd(ppeu_pkg::CMD_TICK, 16'h0080));
    send_req(spawn_of(16'h0100, 16'hFF00, 16'h0000, 16'h00FF, 16'hFF01, 16'h0003,
                      16'hFFFD, 16'h8001, 16'h5A5A, 16'h0080));
    send_req(make_cmd(ppeu_pkg::CMD_TICK, 16'h8000));
    send_req(make_cmd(ppeu_pkg::CMD_TICK, 16'hFFFF));
    send_req(make_cmd(ppeu_pkg::CMD_TICK, 16'h0010));
    send_req(make_spawn());
    send_req(make_spawn());
    send_req(make_cmd(ppeu_pkg::CMD_CLEAR, 16'h0040));
    send_req(make_cmd(ppeu_pkg::CMD_TICK, 16'h0001));
    send_req(spawn_of(16'h0010, 16'h0020, 16'h0030, 16'h0100, 16'h0200, 16'hFE00,
                      16'h0980, 16'h1000, 16'h0F0F, 16'h0200));
    send_req(make_spawn());
    send_req(make_cmd(ppeu_pkg::CMD_TICK, 16'h0020));
    send_req(all_ones);
    send_req(make_cmd(ppeu_pkg::CMD_TICK, 16'h0033));
    wait_drained();

    // full pool reported while the receiver holds off; sender keeps offering
    tx_steady = 1'b1;
    repeat (POOL + 3) send_req(spawn_of(pick_value(), pick_value(), pick_value(),
                                        pick_value(), pick_value(), pick_value(),
                                        pick_value(), 16'($urandom_range(16'h4000, 16'hFFFF)),
                                        16'($urandom), 16'($urandom)));
    hold_off_pending = 1'b1;
    send_req(make_cmd(ppeu_pkg::CMD_TICK, 16'($urandom_range(1, 16'h0100))));
    repeat (6) send_req(make_spawn());
    send_req(make_cmd(ppeu_pkg::CMD_TICK, pick_step()));
    tx_steady = 1'b0;
    wait_drained();

    while (sent < ITEMS) begin
      case ($urandom_range(0, 19))
        0: send_req(make_cmd(ppeu_pkg::CMD_CLEAR, 16'($urandom)));
        1: send_req(make_cmd(CMD_UNUSED, 16'($urandom)));
        default: begin
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 12);
          if (n > ITEMS - sent) n = ITEMS - sent;
          repeat (n) send_req(make_spawn());
          repeat ($urandom_range(1, 4)) send_req(make_cmd(ppeu_pkg::CMD_TICK, pick_step()));
        end
      endcase
      if ($urandom_range(0, 9) == 0) wait_drained();
      if ($urandom_range(0, 5) == 0) tx_steady = !tx_steady;
    end
    wait_drained();

    $display("%0d requests: %0d spawns, %0d ticks, %0d clears; %0d particle updates checked",
             sent, tracker.spawns, tracker.ticks, tracker.clears, tracker.checked);
    $display("largest tick report %0d particles, %0d long receiver hold-offs",
             tracker.peak, long_holds);
    if (tracker.errors == 0) begin
      $display("tb_particle_pool_euler_update: clean");
    end else begin
      $display("tb_particle_pool_euler_update: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/ppeu_pkg.sv
rtl/ppeu_ram.sv
rtl/ppeu_ctrl.sv
rtl/ppeu_dpath.sv
rtl/particle_pool_euler_update.sv
verif/tb_particle_pool_euler_update.sv
